/* src/tcw_pkg.sv */
package tcw_pkg;

  // Screen geometry
  localparam int COLS     = 80;
  localparam int ROWS     = 25;
  localparam int CELLS    = ROWS * COLS;
  localparam int COPY_N   = (ROWS - 1) * COLS;
  localparam int TAB_STEP = 4;

  localparam int ADDR_W = 11;
  localparam int CELL_W = 16;
  localparam int CH_W   = 8;
  localparam int COLOR_W = 4;
  localparam int COL_W  = $clog2(COLS + TAB_STEP);
  localparam int ROW_W  = $clog2(ROWS + 1);

  // Item modes
  localparam logic [1:0] MODE_PUT   = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // Configuration register indexes
  localparam logic CFG_DEFAULT_FG = 1'b0;
  localparam logic CFG_BACKGROUND = 1'b1;

  // Character codes
  localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CH_W-1:0] CH_BS    = 8'h08;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CH_W-1:0] CH_BLANK = 8'h20;

  localparam logic [COLOR_W-1:0] RESET_FG = 4'd7;
  localparam logic [COLOR_W-1:0] RESET_BG = 4'd0;

  // Sequencer states
  typedef enum logic [4:0] {
    S_INIT   = 5'b00001,
    S_IDLE   = 5'b00010,
    S_SCROLL = 5'b00100,
    S_FILL   = 5'b01000,
    S_RESP   = 5'b10000
  } state_t;

  // Command into the cursor unit
  typedef struct packed {
    logic            put;
    logic            clear;
    logic [CH_W-1:0] ch;
  } cur_cmd_t;

  // What a put does to the store
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              scroll;
  } put_res_t;

  function automatic logic [CELL_W-1:0] make_cell(input logic [CH_W-1:0] ch,
                                                  input logic [COLOR_W-1:0] fg,
                                                  input logic [COLOR_W-1:0] bg);
    make_cell = {bg, fg, ch};
  endfunction

  localparam logic [CELL_W-1:0] BLANK_RESET = {RESET_BG, RESET_FG, CH_BLANK};

endpackage

/* src/tcw_screen_mem.sv */
module tcw_screen_mem (
  input  logic                         clk,
  input  logic                         we,
  input  logic [tcw_pkg::ADDR_W-1:0]   waddr,
  input  logic [tcw_pkg::CELL_W-1:0]   wdata,
  input  logic                         re,
  input  logic [tcw_pkg::ADDR_W-1:0]   raddr,
  output logic [tcw_pkg::CELL_W-1:0]   rdata
);

  logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELLS];
  logic [tcw_pkg::CELL_W-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/tcw_cursor.sv */
module tcw_cursor (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tcw_pkg::cur_cmd_t           cmd,
  output tcw_pkg::put_res_t           res,
  output logic [tcw_pkg::ADDR_W-1:0]  cur_pos
);

  logic [tcw_pkg::COL_W-1:0] col_r, col_nxt, col_t;
  logic [tcw_pkg::ROW_W-1:0] row_r, row_nxt, row_t;
  logic                      wr_en, bs, scroll;

  // linear address of the cursor
  assign cur_pos = tcw_pkg::ADDR_W'(tcw_pkg::ADDR_W'(row_r) * tcw_pkg::ADDR_W'(tcw_pkg::COLS)
                   + tcw_pkg::ADDR_W'(col_r));

  // cursor motion for one character
  always_comb begin
    col_t  = col_r;
    row_t  = row_r;
    wr_en  = 1'b0;
    bs     = 1'b0;
    scroll = 1'b0;
    case (cmd.ch)
      tcw_pkg::CH_BS: begin
        if (col_r != '0) begin
          col_t = col_r - 1'b1;
          wr_en = 1'b1;
          bs    = 1'b1;
        end
      end
      tcw_pkg::CH_LF: begin
        col_t = '0;
        row_t = row_r + 1'b1;
      end
      tcw_pkg::CH_CR: begin
        col_t = '0;
      end
      tcw_pkg::CH_TAB: begin
        col_t = col_r + tcw_pkg::COL_W'(tcw_pkg::TAB_STEP);
      end
      default: begin
        wr_en = 1'b1;
        col_t = col_r + 1'b1;
      end
    endcase
    // wrap past the last column
    if (col_t >= tcw_pkg::COL_W'(tcw_pkg::COLS)) begin
      col_t = '0;
      row_t = row_t + 1'b1;
    end
    // past the last row: stay on it, screen scrolls
    if (row_t >= tcw_pkg::ROW_W'(tcw_pkg::ROWS)) begin
      row_t  = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
      scroll = 1'b1;
    end
  end

  assign res.wr_en   = cmd.put & wr_en;
  assign res.wr_addr = bs ? cur_pos - 1'b1 : cur_pos;
  assign res.scroll  = cmd.put & scroll;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cmd.clear) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (cmd.put) begin
      col_nxt = col_t;
      row_nxt = row_t;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

/* src/text_console_writer.sv */
// Channel | Direction | Ports
// in      | input     | in_valid, in_ready, in_mode, in_char_code, in_fg_color, in_cell_index
// out     | output    | out_valid, out_ready, out_cursor_pos, out_cell_value, out_scrolled
// cfg     | input     | cfg_we, cfg_index, cfg_data
//
// Put and read items go through accept (cell write or read issue), then result load.
// Clear blanks the store with one cell write per cycle through the single store write port.
// A put that scrolls copies the screen up a row, one copy per cycle, then blanks the last row.
// After reset a clearing pass over all ROWS*COLS (2000) cells blanks the store; in_ready stays low.
// One item at a time; a result waiting in the output register holds off the next beat.
module text_console_writer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_mode,
  input  logic [7:0]                    in_char_code,
  input  logic [3:0]                    in_fg_color,
  input  logic [10:0]                   in_cell_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [10:0]                   out_cursor_pos,
  output logic [15:0]                   out_cell_value,
  output logic                          out_scrolled,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [3:0]                    cfg_data
);

  tcw_pkg::state_t   state_r, state_nxt;
  logic [tcw_pkg::ADDR_W-1:0] cnt_r, cnt_nxt;
  logic [tcw_pkg::COLOR_W-1:0] default_fg_r, background_r;
  logic              rd_ok_r, rd_ok_nxt;
  logic              scr_r, scr_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [tcw_pkg::ADDR_W-1:0] pos_r, pos_nxt;
  logic [tcw_pkg::CELL_W-1:0] cell_r, cell_nxt;

  logic              accept;
  logic              is_put, is_clear, is_read;
  tcw_pkg::cur_cmd_t cmd;
  tcw_pkg::put_res_t res;
  logic [tcw_pkg::ADDR_W-1:0] cur_pos;

  logic              mem_we, mem_re;
  logic [tcw_pkg::ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [tcw_pkg::CELL_W-1:0] mem_wdata, mem_rdata;
  logic [tcw_pkg::CELL_W-1:0] blank_cell;

  // input handshake and item decode
  assign in_ready = (state_r == tcw_pkg::S_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;
  assign is_put   = accept && (in_mode == tcw_pkg::MODE_PUT) && (in_char_code != tcw_pkg::CH_NUL);
  assign is_clear = accept && (in_mode == tcw_pkg::MODE_CLEAR);
  assign is_read  = accept && (in_mode == tcw_pkg::MODE_READ)
                    && (in_cell_index < tcw_pkg::ADDR_W'(tcw_pkg::CELLS));

  assign cmd.put   = is_put;
  assign cmd.clear = is_clear;
  assign cmd.ch    = in_char_code;

  tcw_cursor u_cursor (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .res     (res),
    .cur_pos (cur_pos)
  );

  assign blank_cell = tcw_pkg::make_cell(tcw_pkg::CH_BLANK, default_fg_r, background_r);

  // store port steering
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_r;
    mem_wdata = blank_cell;
    mem_re    = 1'b0;
    mem_raddr = in_cell_index;
    case (state_r)
      tcw_pkg::S_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = tcw_pkg::BLANK_RESET;
      end
      tcw_pkg::S_IDLE: begin
        mem_we    = res.wr_en;
        mem_waddr = res.wr_addr;
        mem_wdata = tcw_pkg::make_cell(
                      (in_char_code == tcw_pkg::CH_BS) ? tcw_pkg::CH_BLANK : in_char_code,
                      in_fg_color, background_r);
        mem_re    = is_read;
      end
      tcw_pkg::S_SCROLL: begin
        // read one row ahead, write the previous read one row up
        mem_we    = (cnt_r != '0);
        mem_waddr = cnt_r - 1'b1;
        mem_wdata = mem_rdata;
        mem_re    = (cnt_r < tcw_pkg::ADDR_W'(tcw_pkg::COPY_N));
        mem_raddr = cnt_r + tcw_pkg::ADDR_W'(tcw_pkg::COLS);
      end
      tcw_pkg::S_FILL: begin
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  tcw_screen_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rd_ok_nxt     = rd_ok_r;
    scr_nxt       = scr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    pos_nxt       = pos_r;
    cell_nxt      = cell_r;
    case (state_r)
      tcw_pkg::S_INIT: begin
        if (cnt_r == tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1)) begin
          state_nxt = tcw_pkg::S_IDLE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      tcw_pkg::S_IDLE: begin
        if (accept) begin
          rd_ok_nxt = is_read;
          scr_nxt   = res.scroll;
          cnt_nxt   = '0;
          if (res.scroll) begin
            state_nxt = tcw_pkg::S_SCROLL;
          end else if (is_clear) begin
            state_nxt = tcw_pkg::S_FILL;
          end else begin
            state_nxt = tcw_pkg::S_RESP;
          end
        end
      end
      tcw_pkg::S_SCROLL: begin
        if (cnt_r == tcw_pkg::ADDR_W'(tcw_pkg::COPY_N)) begin
          state_nxt = tcw_pkg::S_FILL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      tcw_pkg::S_FILL: begin
        if (cnt_r == tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1)) begin
          state_nxt = tcw_pkg::S_RESP;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      tcw_pkg::S_RESP: begin
        // output register is empty here: only one item is ever in flight
        out_valid_nxt = 1'b1;
        pos_nxt       = cur_pos;
        cell_nxt      = rd_ok_r ? mem_rdata : '0;
        state_nxt     = tcw_pkg::S_IDLE;
      end
      default: begin
        state_nxt = tcw_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcw_pkg::S_INIT;
      cnt_r       <= '0;
      rd_ok_r     <= 1'b0;
      scr_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_ok_r     <= rd_ok_nxt;
      scr_r       <= scr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    cell_r <= cell_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_fg_r <= tcw_pkg::RESET_FG;
      background_r <= tcw_pkg::RESET_BG;
    end else if (cfg_we) begin
      case (cfg_index)
        tcw_pkg::CFG_DEFAULT_FG: default_fg_r <= cfg_data;
        tcw_pkg::CFG_BACKGROUND: background_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cursor_pos = pos_r;
  assign out_cell_value = cell_r;
  assign out_scrolled   = scr_r;

`ifndef SYNTH
  // cursor address stays on the screen
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_cursor_pos < tcw_pkg::ADDR_W'(tcw_pkg::CELLS))
    else $error("cursor address off screen");

  // a scroll leaves the cursor on the last row
  a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_scrolled |-> out_cursor_pos >= tcw_pkg::ADDR_W'(tcw_pkg::COPY_N))
    else $error("scrolled result not on last row");

  // no beat taken while a sweep owns the store
  a_sweep_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tcw_pkg::S_SCROLL || state_r == tcw_pkg::S_FILL
     || state_r == tcw_pkg::S_INIT) |-> !in_ready)
    else $error("input taken during sweep");

  // only an in-range read returns a cell value
  a_cell_zero: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) && !$past(rd_ok_r) |-> out_cell_value == '0)
    else $error("nonzero cell value on non-read item");
`endif

endmodule

/* sim/text_console_writer_tb.sv */
`timescale 1ns / 100ps

module text_console_writer_tb;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int MAX_IDX = 2047;
  localparam int CYCLE_LIMIT = 10_000_000;

  typedef struct {
    logic [1:0]  mode;
    logic [7:0]  code;
    logic [3:0]  fg;
    logic [10:0] idx;
  } console_cmd_t;

  typedef struct {
    logic [10:0] cursor;
    logic [15:0] cell_val;
    logic        scrolled;
  } console_resp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_mode = tcw_pkg::MODE_PUT;
  logic [7:0]  in_char_code = tcw_pkg::CH_NUL;
  logic [3:0]  in_fg_color = 4'd0;
  logic [10:0] in_cell_index = 11'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [10:0] out_cursor_pos;
  logic [15:0] out_cell_value;
  logic        out_scrolled;
  logic        cfg_we = 1'b0;
  logic        cfg_index = tcw_pkg::CFG_DEFAULT_FG;
  logic [3:0]  cfg_data = 4'd0;

  // Shadow copy of the console state
  logic [15:0] shadow_screen [tcw_pkg::CELLS];
  int          shadow_col;
  int          shadow_row;
  logic [3:0]  shadow_default_fg;
  logic [3:0]  shadow_bg;

  console_cmd_t  pending_cmds [$];
  console_resp_t expected_resps [$];
  console_cmd_t  cur_cmd;
  console_resp_t want;
  console_resp_t got;

  bit  in_taken = 1'b0;
  bit  drv_busy = 1'b0;
  bit  hold_off = 1'b0;
  int  drv_gap = 0;
  int  out_stall = 0;
  int  gap_max = 7;
  int  stall_max = 7;
  int  error_count = 0;
  int  cycle_count = 0;

  text_console_writer uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_char_code  (in_char_code),
    .in_fg_color   (in_fg_color),
    .in_cell_index (in_cell_index),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_cursor_pos(out_cursor_pos),
    .out_cell_value(out_cell_value),
    .out_scrolled  (out_scrolled),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    shadow_col = 0;
    shadow_row = 0;
    shadow_default_fg = tcw_pkg::RESET_FG;
    shadow_bg = tcw_pkg::RESET_BG;
    for (int i = 0; i < tcw_pkg::CELLS; i++) shadow_screen[i] = tcw_pkg::BLANK_RESET;
  end

  // Blank a range of the shadow store with the current default colors
  function automatic void blank_cells(int from, int upto);
    for (int i = from; i < upto; i++)
      shadow_screen[i] = {shadow_bg, shadow_default_fg, tcw_pkg::CH_BLANK};
  endfunction

  // Apply one command to the shadow console and return the response it yields
  function automatic console_resp_t run_console_cmd(console_cmd_t c);
    console_resp_t r;
    r.cell_val = 16'h0000;
    r.scrolled = 1'b0;
    case (c.mode)
      tcw_pkg::MODE_PUT: begin
        if (c.code != tcw_pkg::CH_NUL) begin
          case (c.code)
            tcw_pkg::CH_BS: begin
              if (shadow_col > 0) begin
                shadow_col--;
                shadow_screen[shadow_row * tcw_pkg::COLS + shadow_col] =
                  {shadow_bg, c.fg, tcw_pkg::CH_BLANK};
              end
            end
            tcw_pkg::CH_LF: begin
              shadow_col = 0;
              shadow_row++;
            end
            tcw_pkg::CH_CR: shadow_col = 0;
            tcw_pkg::CH_TAB: shadow_col += tcw_pkg::TAB_STEP;
            default: begin
              shadow_screen[shadow_row * tcw_pkg::COLS + shadow_col] = {shadow_bg, c.fg, c.code};
              shadow_col++;
            end
          endcase
          if (shadow_col >= tcw_pkg::COLS) begin
            shadow_col = 0;
            shadow_row++;
          end
          // past the last row: shift everything up one row
          if (shadow_row >= tcw_pkg::ROWS) begin
            for (int i = 0; i < tcw_pkg::COPY_N; i++)
              shadow_screen[i] = shadow_screen[i + tcw_pkg::COLS];
            blank_cells(tcw_pkg::COPY_N, tcw_pkg::CELLS);
            shadow_row = tcw_pkg::ROWS - 1;
            r.scrolled = 1'b1;
          end
        end
      end
      tcw_pkg::MODE_CLEAR: begin
        shadow_col = 0;
        shadow_row = 0;
        blank_cells(0, tcw_pkg::CELLS);
      end
      tcw_pkg::MODE_READ: begin
        if (c.idx < tcw_pkg::CELLS) r.cell_val = shadow_screen[c.idx];
      end
      default: ;
    endcase
    r.cursor = 11'(shadow_row * tcw_pkg::COLS + shadow_col);
    return r;
  endfunction

  // Timeout watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Input beat taken: predict its response
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      expected_resps.push_back(run_console_cmd(cur_cmd));
      in_taken = 1'b1;
    end
  end

  // Input driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        in_taken = 1'b0;
        drv_busy = 1'b0;
        drv_gap = $urandom_range(0, gap_max);
      end
      if (!drv_busy) begin
        if (drv_gap > 0) begin
          drv_gap--;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() > 0 && !hold_off) begin
          cur_cmd = pending_cmds.pop_front();
          in_mode <= cur_cmd.mode;
          in_char_code <= cur_cmd.code;
          in_fg_color <= cur_cmd.fg;
          in_cell_index <= cur_cmd.idx;
          in_valid <= 1'b1;
          drv_busy = 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result side backpressure
  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_stall--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      out_stall = $urandom_range(0, stall_max);
      got.cursor = out_cursor_pos;
      got.cell_val = out_cell_value;
      got.scrolled = out_scrolled;
      if (expected_resps.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected beat: cursor %0d cell %h scrolled %0d",
                   got.cursor, got.cell_val, got.scrolled);
      end else begin
        want = expected_resps.pop_front();
        if (got.cursor !== want.cursor || got.cell_val !== want.cell_val ||
            got.scrolled !== want.scrolled) begin
          error_count++;
          if (error_count <= 10)
            $display("mismatch: cursor exp %0d got %0d, cell exp %h got %h, scr exp %0d got %0d",
                     want.cursor, got.cursor, want.cell_val, got.cell_val,
                     want.scrolled, got.scrolled);
        end
      end
    end
  end

  function automatic void push_cmd(logic [1:0] mode, logic [7:0] code, logic [3:0] fg,
                                   logic [10:0] idx);
    console_cmd_t c;
    c.mode = mode;
    c.code = code;
    c.fg = fg;
    c.idx = idx;
    pending_cmds.push_back(c);
  endfunction

  function automatic logic [3:0] any_fg();
    return 4'($urandom_range(0, 15));
  endfunction

  function automatic logic [10:0] any_idx();
    return 11'($urandom_range(0, MAX_IDX));
  endfunction

  // Queue one burst of related commands with random content
  function automatic void add_burst(inout int count);
    int pick;
    int len;
    logic [7:0] code;
    logic [10:0] idx;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      // a run of text, control codes now and then
      len = $urandom_range(1, 60);
      for (int k = 0; k < len; k++) begin
        code = 8'($urandom_range(0, 255));
        if (code < 8'h20 && $urandom_range(0, 3) != 0) code = 8'($urandom_range(32, 255));
        push_cmd(tcw_pkg::MODE_PUT, code, any_fg(), any_idx());
      end
    end else if (pick < 55) begin
      len = $urandom_range(1, 12);
      for (int k = 0; k < len; k++)
        push_cmd(tcw_pkg::MODE_PUT, tcw_pkg::CH_LF, any_fg(), any_idx());
    end else if (pick < 75) begin
      len = $urandom_range(1, 6);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 4) == 0) idx = 11'($urandom_range(tcw_pkg::CELLS, MAX_IDX));
        else idx = 11'($urandom_range(0, tcw_pkg::CELLS - 1));
        push_cmd(tcw_pkg::MODE_READ, 8'($urandom_range(0, 255)), any_fg(), idx);
      end
    end else if (pick < 96) begin
      if ($urandom_range(0, 1) == 0) begin
        // tabs far enough to run off the line
        len = $urandom_range(1, 22);
        for (int k = 0; k < len; k++)
          push_cmd(tcw_pkg::MODE_PUT, tcw_pkg::CH_TAB, any_fg(), any_idx());
      end else begin
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
          case ($urandom_range(0, 4))
            0: push_cmd(tcw_pkg::MODE_PUT, tcw_pkg::CH_BS, any_fg(), any_idx());
            1: push_cmd(tcw_pkg::MODE_PUT, tcw_pkg::CH_CR, any_fg(), any_idx());
            2: push_cmd(tcw_pkg::MODE_PUT, tcw_pkg::CH_NUL, any_fg(), any_idx());
            3: push_cmd(tcw_pkg::MODE_PUT, tcw_pkg::CH_TAB, any_fg(), any_idx());
            default: push_cmd(MODE_UNUSED, 8'($urandom_range(0, 255)), any_fg(), any_idx());
          endcase
        end
      end
    end else begin
      push_cmd(tcw_pkg::MODE_CLEAR, 8'($urandom_range(0, 255)), any_fg(), any_idx());
    end
    count = pending_cmds.size();
  endfunction

  task automatic wait_idle(int settle);
    while (pending_cmds.size() != 0 || drv_busy || expected_resps.size() != 0)
      @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_colors(logic [3:0] fg, logic [3:0] bg);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= tcw_pkg::CFG_DEFAULT_FG;
    cfg_data <= fg;
    @(negedge clk);
    cfg_index <= tcw_pkg::CFG_BACKGROUND;
    cfg_data <= bg;
    @(negedge clk);
    cfg_we <= 1'b0;
    shadow_default_fg = fg;
    shadow_bg = bg;
  endtask

  // Stimulus sequence
  initial begin
    int queued;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset contents, field extremes, every control code
    push_cmd(tcw_pkg::MODE_READ, 8'hFF, 4'hF, 11'd0);
    push_cmd(tcw_pkg::MODE_READ, 8'h00, 4'h0, 11'(tcw_pkg::CELLS - 1));
    push_cmd(tcw_pkg::MODE_READ, 8'h00, 4'h0, 11'(MAX_IDX));
    push_cmd(tcw_pkg::MODE_PUT, 8'h41, 4'h0, 11'h7FF);
    push_cmd(tcw_pkg::MODE_PUT, 8'hFF, 4'hF, 11'h000);
    push_cmd(tcw_pkg::MODE_PUT, tcw_pkg::CH_NUL, 4'h5, 11'd3);
    push_cmd(tcw_pkg::MODE_PUT, 8'h7E, 4'h9, 11'd0);
    push_cmd(tcw_pkg::MODE_PUT, tcw_pkg::CH_BS, 4'h3, 11'd0);
    push_cmd(tcw_pkg::MODE_READ, 8'h00, 4'h0, 11'd2);
    push_cmd(tcw_pkg::MODE_PUT, tcw_pkg::CH_BS, 4'hC, 11'd0);
    push_cmd(tcw_pkg::MODE_PUT, tcw_pkg::CH_BS, 4'h1, 11'd0);
    push_cmd(tcw_pkg::MODE_PUT, tcw_pkg::CH_BS, 4'h2, 11'd0);
    push_cmd(tcw_pkg::MODE_READ, 8'h00, 4'h0, 11'd0);
    push_cmd(tcw_pkg::MODE_PUT, tcw_pkg::CH_TAB, 4'h0, 11'd0);
    push_cmd(tcw_pkg::MODE_PUT, tcw_pkg::CH_CR, 4'h0, 11'd0);
    push_cmd(tcw_pkg::MODE_PUT, tcw_pkg::CH_TAB, 4'h0, 11'd0);
    push_cmd(tcw_pkg::MODE_PUT, tcw_pkg::CH_LF, 4'h0, 11'd0);
    push_cmd(MODE_UNUSED, 8'h41, 4'hA, 11'd5);
    push_cmd(tcw_pkg::MODE_PUT, 8'h20, 4'h6, 11'd0);
    push_cmd(tcw_pkg::MODE_READ, 8'h00, 4'h0, 11'd80);
    push_cmd(tcw_pkg::MODE_CLEAR, 8'h00, 4'h0, 11'd0);
    push_cmd(tcw_pkg::MODE_READ, 8'h00, 4'h0, 11'd1);
    push_cmd(tcw_pkg::MODE_PUT, 8'h01, 4'h5, 11'd0);
    wait_idle(20);

    // random phases, one color setting each
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: write_colors(4'h0, 4'hF);
        1: write_colors(4'hF, 4'h0);
        2: write_colors(any_fg(), any_fg());
        3: write_colors(4'hF, 4'hF);
        default: write_colors(4'h0, 4'h0);
      endcase
      // one phase runs without random input gaps or output stalls
      gap_max = (p == 2) ? 0 : 7;
      stall_max = (p == 2) ? 0 : 7;
      queued = 0;
      while (queued < 140) add_burst(queued);
      // drain everything in flight once mid-phase
      while (pending_cmds.size() > 70) @(posedge clk);
      hold_off = 1'b1;
      while (drv_busy || expected_resps.size() != 0) @(posedge clk);
      hold_off = 1'b0;
      wait_idle(20);
    end

    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
